@@ src/grid_cell_sparse_set_defines.svh @@
// Assertion macros used by the back end of the grid cell sparse set RTL.
`ifndef GRID_CELL_SPARSE_SET_DEFINES_SVH
`define GRID_CELL_SPARSE_SET_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GCSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gcss_pkg.sv @@
// Shared constants, codes and types of the grid cell sparse set.
package gcss_pkg;

  localparam int MAX_CELLS  = 4096;
  localparam int ID_BITS    = 16;
  localparam int COORD_BITS = 16;

  localparam int CELL_W     = $clog2(MAX_CELLS);
  localparam int CNT_W      = CELL_W + 1;
  localparam int DIM_W      = 13;
  localparam int OFF_W      = (CELL_W < COORD_BITS) ? CELL_W : COORD_BITS;
  localparam int PROD_W     = DIM_W + OFF_W;
  localparam int T_W        = PROD_W + 1;
  localparam int FLAT_W     = DIM_W + CELL_W;
  localparam int CMP_W      = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BOUNDS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OCCUPIED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z    = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_BITS-1:0] body_id;
    logic               inb;
    logic [CELL_W-1:0]  cell_idx;
  } gcss_job_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_BITS-1:0] found_id;
    logic               found;
    logic [CNT_W-1:0]   occupancy;
  } gcss_res_t;

  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] slot;
  } gcss_map_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [CELL_W-1:0]  cell_idx;
  } gcss_ent_t;

endpackage

@@ src/grid_cell_sparse_set.sv @@
// Top level of the grid cell sparse set: front end, back end and port wiring.
//
//   channel  handshake          payload
//   cfg      cfg_valid/ready    cfg_index, cfg_data
//   in       in_push/in_full    in_kind, in_body_id, in_pos_x, in_pos_y, in_pos_z
//   out      out_pop/out_empty  out_status, out_found_id, out_found, out_occupancy
//
// The front computes the cell index in a four-stage pipeline and queues jobs two deep.
// The back takes an item through S_MAP and S_ENT, then S_FIX for a remove that moves
// the last entry, on registered reads of the cell map and packed list memories.
// After reset the cell map is swept one word a cycle, all 4096 words, with in_full held high.
// A full result queue stalls the back, a full job queue stalls the front pipeline.
module grid_cell_sparse_set import gcss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_kind,
  input  logic [ID_BITS-1:0]    in_body_id,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [2:0]            out_status,
  output logic [ID_BITS-1:0]    out_found_id,
  output logic                  out_found,
  output logic [CNT_W-1:0]      out_occupancy
);

  logic      fr_stall;
  logic      bk_clearing;
  logic      in_take;
  logic      q_valid;
  logic      q_pop;
  gcss_job_t q_job;
  gcss_res_t res_head;

  assign cfg_ready = 1'b1;
  assign in_full   = fr_stall || bk_clearing;
  assign in_take   = in_push && !in_full;

  gcss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_take   (in_take),
    .in_stall  (fr_stall),
    .kind      (in_kind),
    .body_id   (in_body_id),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop)
  );

  gcss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .clearing  (bk_clearing),
    .res_empty (out_empty),
    .res_take  (out_pop),
    .res_head  (res_head)
  );

  assign out_status    = res_head.status;
  assign out_found_id  = res_head.found_id;
  assign out_found     = res_head.found;
  assign out_occupancy = res_head.occupancy;

endmodule

@@ src/gcss_front.sv @@
// Front end: configuration registers, cell index pipeline and job queue.
module gcss_front import gcss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_take,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [ID_BITS-1:0]    body_id,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] pos_z,
  output logic                  q_valid,
  output gcss_job_t             q_job,
  input  logic                  q_pop
);

  logic [COORD_BITS-1:0] org_x_r, org_y_r, org_z_r;
  logic [DIM_W-1:0]      dim_x_r, dim_y_r, dim_z_r;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [1:0]            kind1_r, kind2_r, kind3_r, kind4_r;
  logic [ID_BITS-1:0]    id1_r, id2_r, id3_r, id4_r;
  logic [COORD_BITS-1:0] ox1_r, oy1_r, oz1_r;
  logic                  ok2_r, ok3_r, ok4_r;
  logic [OFF_W-1:0]      ox2_r, oy2_r;
  logic [PROD_W-1:0]     prod2_r;
  logic [OFF_W-1:0]      ox3_r, ox4_r;
  logic [CELL_W-1:0]     t3_r;
  logic [FLAT_W-1:0]     prod4_r;

  logic                  adv;
  logic                  q_full;
  logic                  q_push;
  logic                  axis_ok;
  logic                  small_ok;
  logic [T_W-1:0]        t_sum;
  logic [FLAT_W:0]       flat;
  gcss_job_t             job_d;

  gcss_job_t             q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]    q_wp_r, q_rp_r;
  logic [Q_CNT_W-1:0]    q_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dim_x_r <= DIM_W'(16);
      dim_y_r <= DIM_W'(16);
      dim_z_r <= DIM_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_X: org_x_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_ORIGIN_Y: org_y_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_ORIGIN_Z: org_z_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_DIM_X:    dim_x_r <= cfg_wdata[DIM_W-1:0];
        CFG_DIM_Y:    dim_y_r <= cfg_wdata[DIM_W-1:0];
        CFG_DIM_Z:    dim_z_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline holds while its last stage waits on a full queue.
  assign q_full   = (q_cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_push   = v4_r && !q_full;
  assign adv      = !v4_r || !q_full;
  assign in_stall = !adv;

  // An offset at or above the cell count already puts the flat index out of range,
  // which lets the later stages work on truncated offsets.
  assign axis_ok  = (CMP_W'(ox1_r) < CMP_W'(dim_x_r)) && (CMP_W'(oy1_r) < CMP_W'(dim_y_r))
                 && (CMP_W'(oz1_r) < CMP_W'(dim_z_r));
  assign small_ok = (CMP_W'(ox1_r) < CMP_W'(MAX_CELLS)) && (CMP_W'(oy1_r) < CMP_W'(MAX_CELLS))
                 && (CMP_W'(oz1_r) < CMP_W'(MAX_CELLS));

  assign t_sum = T_W'(prod2_r) + T_W'(oy2_r);
  assign flat  = (FLAT_W + 1)'(prod4_r) + (FLAT_W + 1)'(ox4_r);

  always_comb begin
    job_d.kind     = kind4_r;
    job_d.body_id  = id4_r;
    job_d.inb      = ok4_r && (CMP_W'(flat) < CMP_W'(MAX_CELLS));
    job_d.cell_idx = flat[CELL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= kind;
      id1_r   <= body_id;
      ox1_r   <= pos_x - org_x_r;
      oy1_r   <= pos_y - org_y_r;
      oz1_r   <= pos_z - org_z_r;

      kind2_r <= kind1_r;
      id2_r   <= id1_r;
      ok2_r   <= axis_ok && small_ok;
      ox2_r   <= ox1_r[OFF_W-1:0];
      oy2_r   <= oy1_r[OFF_W-1:0];
      prod2_r <= PROD_W'(dim_y_r) * PROD_W'(oz1_r[OFF_W-1:0]);

      kind3_r <= kind2_r;
      id3_r   <= id2_r;
      ok3_r   <= ok2_r && (CMP_W'(t_sum) < CMP_W'(MAX_CELLS));
      ox3_r   <= ox2_r;
      t3_r    <= t_sum[CELL_W-1:0];

      kind4_r <= kind3_r;
      id4_r   <= id3_r;
      ok4_r   <= ok3_r;
      ox4_r   <= ox3_r;
      prod4_r <= FLAT_W'(dim_x_r) * FLAT_W'(t3_r);
    end
  end

  assign q_valid = (q_cnt_r != '0);
  assign q_job   = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (q_pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wp_r] <= job_d;
    end
  end

endmodule

@@ src/gcss_back.sv @@
// Back end: cell map and packed list memories, operation sequencer and result queue.
`include "grid_cell_sparse_set_defines.svh"

module gcss_back import gcss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  gcss_job_t q_job,
  output logic      q_pop,
  output logic      clearing,
  output logic      res_empty,
  input  logic      res_take,
  output gcss_res_t res_head
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MAP   = 5'b00100,
    S_ENT   = 5'b01000,
    S_FIX   = 5'b10000
  } gcss_state_t;

  gcss_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CELL_W-1:0]  clr_r, clr_nxt;

  gcss_job_t          job_r;
  logic               held_r;
  logic [CELL_W-1:0]  slot_r;
  logic [CELL_W-1:0]  mc_r;

  gcss_map_t          map_mem [MAX_CELLS];
  gcss_map_t          map_rd_r;
  logic [CELL_W-1:0]  map_raddr;
  logic               map_we;
  logic [CELL_W-1:0]  map_waddr;
  gcss_map_t          map_wdata;

  gcss_ent_t          ent_mem [MAX_CELLS];
  gcss_ent_t          ent_a_r, ent_b_r;
  logic [CELL_W-1:0]  ent_ra;
  logic               ent_we;
  logic [CELL_W-1:0]  ent_wa;
  gcss_ent_t          ent_wd;

  logic [CNT_W-1:0]   last_w;
  logic [CELL_W-1:0]  last;
  logic               list_full;
  logic               res_push;
  gcss_res_t          res_d;

  gcss_res_t          res_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] res_wp_r, res_rp_r;
  logic [Q_CNT_W-1:0] res_cnt_r;
  logic               res_pop;

  assign clearing  = (state_r == S_CLEAR);
  assign last_w    = count_r - CNT_W'(1);
  assign last      = last_w[CELL_W-1:0];
  assign list_full = (count_r >= CNT_W'(MAX_CELLS));

  // A job is taken only when its result is sure of a place in the result queue.
  assign q_pop = (state_r == S_IDLE) && q_valid && (res_cnt_r != Q_CNT_W'(Q_DEPTH));

  assign map_raddr = (state_r == S_IDLE) ? q_job.cell_idx : job_r.cell_idx;
  assign ent_ra    = map_rd_r.slot;

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    clr_nxt            = clr_r;
    map_we             = 1'b0;
    map_waddr          = job_r.cell_idx;
    map_wdata          = '0;
    ent_we             = 1'b0;
    ent_wa             = count_r[CELL_W-1:0];
    ent_wd.id          = job_r.body_id;
    ent_wd.cell_idx    = job_r.cell_idx;
    res_push           = 1'b0;
    res_d.status       = ST_OK;
    res_d.found_id     = held_r ? ent_a_r.id : '0;
    res_d.found        = held_r;
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CELL_W'(MAX_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        state_nxt = S_ENT;
      end
      S_ENT: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
        unique case (job_r.kind)
          KIND_ADD: begin
            priority if (list_full) begin
              res_d.status = ST_FULL;
            end else if (!job_r.inb) begin
              res_d.status = ST_BOUNDS;
            end else if (held_r) begin
              res_d.status = ST_OCCUPIED;
            end else begin
              ent_we          = 1'b1;
              map_we          = 1'b1;
              map_wdata.valid = 1'b1;
              map_wdata.slot  = count_r[CELL_W-1:0];
              count_nxt       = count_r + CNT_W'(1);
            end
          end
          KIND_REMOVE: begin
            priority if (!job_r.inb) begin
              res_d.status = ST_BOUNDS;
            end else if (!held_r) begin
              res_d.status = ST_EMPTY;
            end else if (ent_a_r.id != job_r.body_id) begin
              res_d.status = ST_MISMATCH;
            end else begin
              // The cell is freed now; the moved entry's cell is relinked next cycle.
              map_we    = 1'b1;
              count_nxt = count_r - CNT_W'(1);
              if (slot_r != last) begin
                ent_we    = 1'b1;
                ent_wa    = slot_r;
                ent_wd    = ent_b_r;
                state_nxt = S_FIX;
              end
            end
          end
          default: begin
            priority if (!job_r.inb) begin
              res_d.status = ST_BOUNDS;
            end else if (!held_r) begin
              res_d.status = ST_EMPTY;
            end else begin
              res_d.status = ST_OK;
            end
          end
        endcase
      end
      S_FIX: begin
        map_we          = 1'b1;
        map_waddr       = mc_r;
        map_wdata.valid = 1'b1;
        map_wdata.slot  = slot_r;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res_d.occupancy = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == S_MAP) begin
      held_r <= job_r.inb && map_rd_r.valid;
      slot_r <= map_rd_r.slot;
    end
    if (state_r == S_ENT) begin
      mc_r <= ent_b_r.cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    map_rd_r <= map_mem[map_raddr];
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ent_a_r <= ent_mem[ent_ra];
    ent_b_r <= ent_mem[last];
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
  end

  assign res_empty = (res_cnt_r == '0);
  assign res_pop   = res_take && !res_empty;
  assign res_head  = res_mem_r[res_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= '0;
      res_rp_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wp_r <= res_wp_r + 1'b1;
      end
      if (res_pop) begin
        res_rp_r <= res_rp_r + 1'b1;
      end
      res_cnt_r <= res_cnt_r + Q_CNT_W'(res_push) - Q_CNT_W'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wp_r] <= res_d;
    end
  end

  `GCSS_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CNT_W'(MAX_CELLS), "entry count beyond capacity")
  `GCSS_ASSERT_IMPL(a_no_pop_in_clear, state_r == S_CLEAR, !q_pop, "job taken during map clear")
  `GCSS_ASSERT_IMPL(a_res_room, res_push, res_cnt_r != Q_CNT_W'(Q_DEPTH), "result queue overflow")
  `GCSS_ASSERT_NEXT(a_add_grows, res_push && job_r.kind == KIND_ADD && res_d.status == ST_OK, count_r == $past(count_r) + CNT_W'(1), "add did not grow the list")

endmodule

@@ tb/grid_cell_sparse_set_tb.sv @@
// Self-checking testbench for the grid cell sparse set: add, remove and look-up traffic.
module grid_cell_sparse_set_tb;
  import gcss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          FILL_STRIDE     = 1237;
  localparam int          FILL_COUNT      = 128;
  localparam logic [1:0]  KIND_LOOKUP_ALT = 2'd3;

  typedef struct {
    logic [1:0]            kind;
    logic [ID_BITS-1:0]    body_id;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] pz;
  } grid_op_t;

  typedef struct {
    logic [2:0]         status;
    logic [ID_BITS-1:0] found_id;
    logic               found;
    logic [CNT_W-1:0]   occupancy;
  } grid_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [1:0]            in_kind = '0;
  logic [ID_BITS-1:0]    in_body_id = '0;
  logic [COORD_BITS-1:0] in_pos_x = '0;
  logic [COORD_BITS-1:0] in_pos_y = '0;
  logic [COORD_BITS-1:0] in_pos_z = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [2:0]            out_status;
  logic [ID_BITS-1:0]    out_found_id;
  logic                  out_found;
  logic [CNT_W-1:0]      out_occupancy;

  grid_cell_sparse_set dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_body_id    (in_body_id),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_found_id  (out_found_id),
    .out_found     (out_found),
    .out_occupancy (out_occupancy)
  );

  always #6 clk = ~clk;

  grid_op_t     op_backlog[$];
  grid_report_t expected_reports[$];
  int           idle_pct = 19;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Shadow of the block's registers and storage, updated as items are accepted.
  logic [15:0]        shadow_org_x = '0, shadow_org_y = '0, shadow_org_z = '0;
  logic [DIM_W-1:0]   shadow_dim_x = 13'd16, shadow_dim_y = 13'd16, shadow_dim_z = 13'd16;
  logic               cell_used [MAX_CELLS];
  logic [CELL_W-1:0]  cell_slot [MAX_CELLS];
  logic [ID_BITS-1:0] slot_body [MAX_CELLS];
  logic [CELL_W-1:0]  slot_cell [MAX_CELLS];
  int unsigned        body_count = 0;

  // The grid that the stimulus is currently aimed at.
  logic [15:0] gen_org_x, gen_org_y, gen_org_z;
  int unsigned gen_dim_x, gen_dim_y, gen_dim_z;
  logic [ID_BITS-1:0] fill_id [MAX_CELLS];

  function automatic grid_report_t apply_grid_op(input logic [1:0] kind,
                                                 input logic [ID_BITS-1:0] id,
                                                 input logic [15:0] px, py, pz);
    logic [15:0]        ox, oy, oz;
    logic [63:0]        flat;
    logic               inb;
    logic               held;
    logic [CELL_W-1:0]  cell_idx, slot, last, moved;
    logic [ID_BITS-1:0] held_id;
    grid_report_t       r;
    ox = px - shadow_org_x;
    oy = py - shadow_org_y;
    oz = pz - shadow_org_z;
    flat = 64'(ox) + 64'(oy) * 64'(shadow_dim_x)
         + 64'(oz) * 64'(shadow_dim_x) * 64'(shadow_dim_y);
    inb = (ox < shadow_dim_x) && (oy < shadow_dim_y) && (oz < shadow_dim_z) &&
          (flat < 64'(MAX_CELLS));
    cell_idx = flat[CELL_W-1:0];
    held = inb && cell_used[cell_idx];
    slot = cell_slot[cell_idx];
    held_id = held ? slot_body[slot] : '0;
    case (kind)
      KIND_ADD: begin
        if (body_count >= MAX_CELLS) begin
          r.status = ST_FULL;
        end else if (!inb) begin
          r.status = ST_BOUNDS;
        end else if (held) begin
          r.status = ST_OCCUPIED;
        end else begin
          slot_body[body_count] = id;
          slot_cell[body_count] = cell_idx;
          cell_used[cell_idx] = 1'b1;
          cell_slot[cell_idx] = CELL_W'(body_count);
          body_count++;
          r.status = ST_OK;
        end
      end
      KIND_REMOVE: begin
        if (!inb) begin
          r.status = ST_BOUNDS;
        end else if (!held) begin
          r.status = ST_EMPTY;
        end else if (held_id != id) begin
          r.status = ST_MISMATCH;
        end else begin
          // The last entry fills the hole and its cell is pointed at the new slot.
          last = CELL_W'(body_count - 1);
          if (slot != last) begin
            moved = slot_cell[last];
            slot_body[slot] = slot_body[last];
            slot_cell[slot] = moved;
            cell_slot[moved] = slot;
          end
          body_count--;
          cell_used[cell_idx] = 1'b0;
          cell_slot[cell_idx] = '0;
          r.status = ST_OK;
        end
      end
      default: begin
        if (!inb) r.status = ST_BOUNDS;
        else if (!held) r.status = ST_EMPTY;
        else r.status = ST_OK;
      end
    endcase
    r.found_id = held_id;
    r.found = held;
    r.occupancy = CNT_W'(body_count);
    return r;
  endfunction

  function automatic logic [ID_BITS-1:0] body_tag(input logic [15:0] px, py, pz);
    return px ^ {py[7:0], py[15:8]} ^ {pz[12:0], pz[15:13]};
  endfunction

  // Large axes lean towards small offsets so that the flat index often fits.
  function automatic logic [15:0] pick_offset(input int unsigned dim);
    int unsigned r;
    r = $urandom_range(99);
    if (dim == 0) return 16'($urandom);
    if (dim > 64 && r < 50) return (r < 30) ? 16'd0 : 16'($urandom_range(3));
    return 16'($urandom_range(dim - 1));
  endfunction

  task automatic queue_op(input logic [1:0] kind, input logic [ID_BITS-1:0] id,
                          input logic [15:0] px, py, pz);
    grid_op_t op;
    op.kind = kind;
    op.body_id = id;
    op.px = px;
    op.py = py;
    op.pz = pz;
    op_backlog.push_back(op);
  endtask

  task automatic queue_random(input int n);
    int unsigned k;
    logic [1:0]  kind;
    logic [15:0] px, py, pz;
    logic [ID_BITS-1:0] id;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 40) kind = KIND_ADD;
      else if (k < 70) kind = KIND_REMOVE;
      else if (k < 95) kind = KIND_LOOKUP;
      else kind = KIND_LOOKUP_ALT;
      if ($urandom_range(99) < 12) begin
        px = 16'($urandom);
        py = 16'($urandom);
        pz = 16'($urandom);
      end else begin
        px = gen_org_x + pick_offset(gen_dim_x);
        py = gen_org_y + pick_offset(gen_dim_y);
        pz = gen_org_z + pick_offset(gen_dim_z);
      end
      id = ($urandom_range(99) < 15) ? ID_BITS'($urandom) : body_tag(px, py, pz);
      queue_op(kind, id, px, py, pz);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [15:0] ox, oy, oz, input int unsigned dx, dy, dz);
    gen_org_x = ox;
    gen_org_y = oy;
    gen_org_z = oz;
    gen_dim_x = dx;
    gen_dim_y = dy;
    gen_dim_z = dz;
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIM_X, CFG_DATA_W'(dx));
    write_reg(CFG_DIM_Y, CFG_DATA_W'(dy));
    write_reg(CFG_DIM_Z, CFG_DATA_W'(dz));
  endtask

  task automatic wait_idle();
    while (op_backlog.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: items and pops change on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_push    <= 1'b1;
        in_kind    <= op_backlog[0].kind;
        in_body_id <= op_backlog[0].body_id;
        in_pos_x   <= op_backlog[0].px;
        in_pos_y   <= op_backlog[0].py;
        in_pos_z   <= op_backlog[0].pz;
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: results, accepted items and register writes, all seen at the rising edge.
  always @(posedge clk) begin : monitor
    grid_report_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d found_id %0h",
                   $time, out_status, out_found_id);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_found_id !== want.found_id) begin
            $display("%0t: found_id expected %0h actual %0h", $time, want.found_id,
                     out_found_id);
            fail_count++;
          end
          if (out_found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
            fail_count++;
          end
          if (out_occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     out_occupancy);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        void'(op_backlog.pop_front());
        expected_reports.push_back(apply_grid_op(in_kind, in_body_id,
                                                 in_pos_x, in_pos_y, in_pos_z));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X: shadow_org_x = cfg_data;
          CFG_ORIGIN_Y: shadow_org_y = cfg_data;
          CFG_ORIGIN_Z: shadow_org_z = cfg_data;
          CFG_DIM_X:    shadow_dim_x = cfg_data[DIM_W-1:0];
          CFG_DIM_Y:    shadow_dim_y = cfg_data[DIM_W-1:0];
          CFG_DIM_Z:    shadow_dim_z = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned c;
    for (int i = 0; i < MAX_CELLS; i++) begin
      cell_used[i] = 1'b0;
      cell_slot[i] = '0;
    end
    gen_org_x = '0;
    gen_org_y = '0;
    gen_org_z = '0;
    gen_dim_x = 16;
    gen_dim_y = 16;
    gen_dim_z = 16;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed items on the grid left by reset.
    queue_op(KIND_LOOKUP, 16'h0000, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_REMOVE, 16'h0000, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_ADD, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_ADD, 16'h0001, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_LOOKUP, 16'h0000, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_REMOVE, 16'h1234, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_ADD, 16'h0000, 16'd15, 16'd15, 16'd15);
    queue_op(KIND_LOOKUP_ALT, 16'h0000, 16'd15, 16'd15, 16'd15);
    queue_op(KIND_ADD, 16'h0007, 16'd16, 16'd0, 16'd0);
    queue_op(KIND_ADD, 16'h0007, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_op(KIND_REMOVE, 16'h0000, 16'd0, 16'd16, 16'd0);
    queue_op(KIND_LOOKUP, 16'h0000, 16'd0, 16'd0, 16'd16);
    queue_op(KIND_ADD, 16'h0002, 16'd1, 16'd0, 16'd0);
    queue_op(KIND_REMOVE, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    queue_op(KIND_REMOVE, 16'h0000, 16'd15, 16'd15, 16'd15);
    queue_op(KIND_REMOVE, 16'h0002, 16'd1, 16'd0, 16'd0);
    wait_idle();

    // Fill the low cells of the 16x16x16 grid without gaps, then empty them in a
    // scattered order so that most removes move the last entry.
    idle_pct = 0;
    for (int i = 0; i < FILL_COUNT; i++) begin
      fill_id[i] = ID_BITS'($urandom);
      queue_op(KIND_ADD, fill_id[i], 16'(i % 16), 16'((i / 16) % 16), 16'(i / 256));
    end
    queue_op(KIND_ADD, 16'h5555, 16'd3, 16'd3, 16'd0);
    queue_op(KIND_ADD, 16'h5555, 16'd20, 16'd0, 16'd0);
    queue_op(KIND_LOOKUP, 16'h0000, 16'd5, 16'd0, 16'd0);
    queue_op(KIND_REMOVE, fill_id[5] ^ 16'h0001, 16'd5, 16'd0, 16'd0);
    wait_idle();
    idle_pct = 19;
    for (int i = 0; i < FILL_COUNT; i++) begin
      c = (i * FILL_STRIDE) % FILL_COUNT;
      queue_op(KIND_REMOVE, fill_id[c], 16'(c % 16), 16'((c / 16) % 16), 16'(c / 256));
      if (i % 64 == 0) queue_op(KIND_LOOKUP, 16'h0000, 16'(c % 16), 16'((c / 16) % 16),
                                16'(c / 256));
    end
    wait_idle();

    // Random traffic over a series of grids, the extremes among them.
    set_grid(16'h0100, 16'h2000, 16'h0007, 4, 4, 2);
    queue_random(50);
    wait_idle();
    queue_random(50);
    wait_idle();

    set_grid(16'hFFFF, 16'hFFFE, 16'hFFF0, 5, 3, 7);
    queue_random(100);
    wait_idle();

    set_grid(16'h0000, 16'h0000, 16'h0000, 4096, 1, 1);
    queue_random(100);
    wait_idle();

    set_grid(16'h0000, 16'h0000, 16'h0000, 4096, 4096, 4096);
    // The flat index spills past the last cell although every axis is in range.
    queue_op(KIND_ADD, 16'h00A5, 16'd0, 16'd1, 16'd0);
    queue_op(KIND_ADD, 16'h00A6, 16'd4095, 16'd0, 16'd0);
    queue_op(KIND_LOOKUP, 16'h0000, 16'd4095, 16'd0, 16'd0);
    wait_idle();
    gen_org_x = 16'($urandom);
    gen_org_y = 16'($urandom);
    gen_org_z = 16'($urandom);
    set_grid(gen_org_x, gen_org_y, gen_org_z, 4096, 4096, 4096);
    queue_random(100);
    wait_idle();

    set_grid(16'($urandom), 16'($urandom), 16'($urandom), 1, 1, 1);
    queue_random(80);
    wait_idle();

    // A zero dimension leaves no cell in bounds.
    set_grid(16'($urandom), 16'($urandom), 16'($urandom), 3, 6, 0);
    queue_random(30);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_grid(16'($urandom), 16'($urandom), 16'($urandom),
               $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
      queue_random(100);
      wait_idle();
    end

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
